FILE: hw/rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

   // Header layout: 32-bit length then 16-bit type, both big-endian
   localparam int unsigned HEADER_BYTES = 6;
   localparam int unsigned COUNT_W      = 3;
   localparam int unsigned LEN_W        = 32;
   localparam int unsigned TYPE_W       = 16;
   localparam int unsigned BYTE_W       = 8;

   // Reset value of the maximum body length register
   localparam logic [LEN_W-1:0] MAX_BODY_LEN_RESET = 32'd1048576;

   // Last header byte position, as a counter value
   localparam logic [COUNT_W-1:0] HEADER_LAST = COUNT_W'(HEADER_BYTES - 1);

   // Deframer phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   // Result kind carried on tuser
   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Result payload: body byte, message type, length (lowest field first)
   typedef struct packed {
      logic [LEN_W-1:0]  bad_length;
      logic [TYPE_W-1:0] msg_type;
      logic [BYTE_W-1:0] body_byte;
   } rsp_data_type;

endpackage

FILE: hw/rtl/length_prefixed_deframer.sv
// Length-prefixed deframer: header parse, body pass-through, oversize trap.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata[7:0] stream byte
//   rsp      out        rsp_tvalid/rsp_tready  tdata body/type/length, tuser kind, tlast
//   csr      in         csr_valid/csr_ready    csr_data max body length
//
// One byte is taken per cycle while the output register is empty or draining;
// each beat is decoded in the cycle it is accepted and any result lands in the
// output register on the same edge. A result is visible in the cycle after its
// byte and waits there while rsp_tready is low; a new byte is still taken in that
// cycle if the output register is empty or being drained. Synchronous reset returns
// to header collection and clears the sticky error phase; csr_ready is always high.
module length_prefixed_deframer (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] body_byte, [23:8] msg_type, [55:24] bad_length
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // last_of_body
   // Configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // max_body_len
);

   lpd_pkg::phase_type              phase_ff, phase_in;
   logic [lpd_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [lpd_pkg::LEN_W-1:0]       length_ff, length_in;
   logic [lpd_pkg::TYPE_W-1:0]      type_ff, type_in;
   logic [lpd_pkg::LEN_W-1:0]       remain_ff, remain_in;
   logic [lpd_pkg::LEN_W-1:0]       max_len_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_data_type           rsp_data_ff, rsp_data_in;
   lpd_pkg::kind_type               rsp_kind_ff, rsp_kind_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            req_beat;
   logic                            produce;
   logic [lpd_pkg::LEN_W-1:0]       hdr_length;
   logic [lpd_pkg::TYPE_W-1:0]      hdr_type;

   // Take a byte when the output register is free or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Header shift: type byte moves up into the length word
   assign hdr_length = {length_ff[lpd_pkg::LEN_W-9:0], type_ff[lpd_pkg::TYPE_W-1:8]};
   assign hdr_type   = {type_ff[7:0], req_tdata};

   // Next state and result for the beat being accepted
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      type_in     = type_ff;
      remain_in   = remain_ff;
      produce     = 1'b0;
      rsp_kind_in = lpd_pkg::KIND_BODY;
      rsp_last_in = 1'b0;
      rsp_data_in = '0;

      if (req_beat) begin
         case (phase_ff)
            lpd_pkg::PH_HEADER: begin
               length_in = hdr_length;
               type_in   = hdr_type;
               count_in  = count_ff + 1'b1;
               if (count_ff == lpd_pkg::HEADER_LAST) begin
                  count_in             = '0;
                  rsp_data_in.msg_type = hdr_type;
                  if (hdr_length > max_len_ff) begin
                     // Oversize: report once and trap
                     phase_in               = lpd_pkg::PH_ERROR;
                     produce                = 1'b1;
                     rsp_kind_in            = lpd_pkg::KIND_ERROR;
                     rsp_data_in.bad_length = hdr_length;
                  end else if (hdr_length == '0) begin
                     produce     = 1'b1;
                     rsp_kind_in = lpd_pkg::KIND_EMPTY;
                     rsp_last_in = 1'b1;
                  end else begin
                     remain_in = hdr_length;
                     phase_in  = lpd_pkg::PH_BODY;
                  end
               end
            end
            lpd_pkg::PH_BODY: begin
               produce                = 1'b1;
               rsp_kind_in            = lpd_pkg::KIND_BODY;
               rsp_data_in.body_byte  = req_tdata;
               rsp_data_in.msg_type   = type_ff;
               rsp_data_in.bad_length = length_ff;
               if (remain_ff <= lpd_pkg::LEN_W'(1)) begin
                  rsp_last_in = 1'b1;
                  remain_in   = '0;
                  phase_in    = lpd_pkg::PH_HEADER;
               end else begin
                  remain_in = remain_ff - 1'b1;
               end
            end
            default: begin
               // Error phase (and any stray code): drop the byte
               phase_in = phase_ff;
            end
         endcase
      end

      // Output register valid: load, drain or hold
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpd_pkg::PH_HEADER;
         count_ff     <= '0;
         length_ff    <= '0;
         type_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         type_ff      <= type_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lpd_pkg::MAX_BODY_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   // Result payload: load only with a new result
   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An error result always leaves the block trapped
   a_error_traps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lpd_pkg::KIND_ERROR) |-> (phase_ff == lpd_pkg::PH_ERROR))
      else $error("error result without error phase");

   // An empty packet ends its body and carries no length
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lpd_pkg::KIND_EMPTY) |->
         (rsp_tlast && rsp_tdata[55:24] == '0 && rsp_tdata[7:0] == '0))
      else $error("malformed empty packet result");

   // Body phase always has bytes left to pass on
   a_body_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpd_pkg::PH_BODY) |-> (remain_ff != '0))
      else $error("body phase with nothing remaining");

   // Header counter stays within the header
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= lpd_pkg::HEADER_LAST) && (phase_ff == lpd_pkg::PH_HEADER || count_ff == '0))
      else $error("header counter out of range");

   // A stalled result is not overwritten by a new byte
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

endmodule
